// ===== hw/rtl/lpn_pkg.sv =====
// Package: shared constants and types for the Lp vector normalizer.
`default_nettype none
package lpn_pkg;
  localparam int MaxLenDef     = 64;
  localparam int SampleBitsDef = 16;
  localparam int AccBits       = 37;
  localparam int L2Guard       = 8;
  localparam int CfgBits       = 7;
  localparam int IdxBits       = 1;
  localparam logic [IdxBits-1:0] RegNormOrder = 1'd0;
  localparam logic [IdxBits-1:0] RegVecLen    = 1'd1;
  localparam logic [1:0] OrderL1 = 2'd1;
  typedef logic [AccBits-1:0] acc_t;
endpackage
`default_nettype wire

// ===== hw/rtl/lp_vector_normalizer.sv =====
// Top level: Lp (L1 / L2) vector normalizer over a sample memory.
//
// channel  ports                         handshake
// -------  ----------------------------  ------------------------------
// input    in_sample                     start & !busy
// result   out_out_value, out_last       out_valid, one cycle, no stall
// config   cfg_we, cfg_index, cfg_data   cfg_we, immediate
//
// Each request is stored when it is accepted. After the last sample of a vector the
// block reads the memory once per sample to accumulate, forms the norm with a
// bit-serial square root (L2 only), then per sample reads the memory and runs a
// bit-serial divider: a read state, the divide steps and an output state for
// each result.
// busy stays high from the cycle after the last sample until the final result
// shows; a new request can be taken in that same cycle.
// Reset is synchronous, active low; the sample memory is not cleared.
// The receiver cannot stall: every result shows for exactly one cycle.
`default_nettype none
module lp_vector_normalizer #(
  parameter int MAX_LEN     = lpn_pkg::MaxLenDef,
  parameter int SAMPLE_BITS = lpn_pkg::SampleBitsDef
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                               out_valid,
  output logic signed [SAMPLE_BITS-1:0]      out_out_value,
  output logic                               out_last,
  input  wire logic                          cfg_we,
  input  wire logic [lpn_pkg::IdxBits-1:0]   cfg_index,
  input  wire logic [lpn_pkg::CfgBits-1:0]   cfg_data
);
  import lpn_pkg::*;

  localparam int AW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW  = $clog2(MAX_LEN + 1);
  localparam int F   = SAMPLE_BITS - 1;
  // numerator width: magnitude shifted by F+Guard
  localparam int NW  = SAMPLE_BITS + F + L2Guard;
  localparam int RW  = (AccBits + 2 * L2Guard + 1) / 2;  // root bits
  localparam int SQW = 2 * RW;                            // sqrt operand bits, even
  localparam int DW  = (RW > AccBits) ? RW : AccBits;
  localparam int SQI = RW;                                // sqrt iterations
  localparam int QW  = NW + 1;

  localparam logic [2:0] S_IDLE = 3'd0, S_ACC = 3'd1, S_SQRT = 3'd2,
                         S_RD = 3'd3, S_DIV = 3'd4, S_OUT = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [1:0] order_r;
  logic [CfgBits-1:0] vlen_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] rd_cnt_r;
  logic [CW-1:0] n_r;
  logic l1_r;
  acc_t acc_r;
  logic [DW-1:0] norm_r;
  logic [SQW+1:0] sq_rem_r;
  logic [RW-1:0] sq_root_r;
  logic [SQW-1:0] sq_op_r;
  logic [6:0] step_r;
  logic [NW-1:0] num_r;
  logic [DW:0] rem_r;
  logic neg_r;
  logic rd_valid_r;

  // sample memory, one write and one registered read per cycle
  logic [SAMPLE_BITS-1:0] mem [MAX_LEN];
  logic [SAMPLE_BITS-1:0] rd_data_r;
  logic [AW-1:0] rd_addr;

  // effective length, clamped to 1..MAX_LEN
  logic [CW-1:0] len_eff;
  always_comb begin
    if (vlen_r == '0) len_eff = CW'(1);
    else if (32'(vlen_r) > MAX_LEN) len_eff = CW'(MAX_LEN);
    else len_eff = CW'(vlen_r);
  end

  logic accept;
  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  logic vec_done;
  assign vec_done = accept && (count_r + CW'(1) >= len_eff);

  assign rd_addr = rd_cnt_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (accept && (32'(count_r) < MAX_LEN)) mem[count_r[AW-1:0]] <= in_sample;
    rd_data_r <= mem[rd_addr];
  end

  // magnitude of the read sample
  logic rd_neg;
  logic [SAMPLE_BITS-1:0] rd_mag;
  assign rd_neg = rd_data_r[SAMPLE_BITS-1];
  assign rd_mag = rd_neg ? (~rd_data_r + 1'b1) : rd_data_r;

  logic [2*SAMPLE_BITS-1:0] sq;
  assign sq = rd_mag * rd_mag;
  logic [AccBits:0] add_sum;
  assign add_sum = {1'b0, acc_r} +
                   (l1_r ? (AccBits+1)'(rd_mag) : (AccBits+1)'(sq));

  // sqrt step (restoring, two bits per cycle)
  logic [SQW+1:0] sq_trial, sq_rem_sh;
  assign sq_rem_sh = {sq_rem_r[SQW-1:0], sq_op_r[SQW-1 -: 2]};
  assign sq_trial  = sq_rem_sh - (SQW+2)'({sq_root_r, 2'b01});

  // divide step: remainder shift-in of numerator msb
  logic [DW+1:0] div_sh, div_tr;
  assign div_sh = {rem_r, num_r[NW-1]};
  assign div_tr = div_sh - (DW+2)'(norm_r);

  logic [QW-1:0] quo_r;
  // round to nearest: bump the quotient when twice the remainder reaches the divisor
  logic [DW+1:0] rem2;
  logic [QW-1:0] q_r;
  assign rem2 = {rem_r, 1'b0};
  assign q_r  = quo_r + QW'(rem2 >= (DW+2)'(norm_r));

  logic [SAMPLE_BITS-1:0] out_v;
  localparam logic [QW-1:0] One = QW'(1) << F;
  always_comb begin
    logic [QW-1:0] q;
    q = q_r;
    if (norm_r == '0) q = '0;
    if (neg_r) begin
      if (q > One) q = One;
      out_v = SAMPLE_BITS'(~q + 1'b1);
    end else begin
      if (q > One - 1'b1) q = One - 1'b1;
      out_v = SAMPLE_BITS'(q);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (vec_done) state_nxt = S_ACC;
      S_ACC:  if (rd_valid_r && (rd_cnt_r == n_r)) state_nxt = l1_r ? S_RD : S_SQRT;
      S_SQRT: if (step_r == 7'(SQI - 1)) state_nxt = S_RD;
      S_RD:   state_nxt = S_DIV;
      S_DIV:  if (step_r == 7'(NW)) state_nxt = S_OUT;
      S_OUT:  state_nxt = (rd_cnt_r == n_r) ? S_IDLE : S_RD;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      order_r    <= 2'd2;
      vlen_r     <= CfgBits'(64);
      count_r    <= '0;
      rd_cnt_r   <= '0;
      rd_valid_r <= 1'b0;
      acc_r      <= '0;
      out_valid  <= 1'b0;
      step_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          RegNormOrder: order_r <= cfg_data[1:0];
          RegVecLen:    vlen_r  <= cfg_data;
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) count_r <= count_r + CW'(1);
          if (vec_done) begin
            // hold length and order for the whole vector
            n_r        <= (32'(count_r) + 1 > MAX_LEN) ? CW'(MAX_LEN) : count_r + CW'(1);
            l1_r       <= (order_r == OrderL1);
            count_r    <= '0;
            rd_cnt_r   <= '0;
            rd_valid_r <= 1'b0;
            acc_r      <= '0;
          end
        end
        S_ACC: begin
          // advance read pointer; accumulate the sample read last cycle
          if (rd_cnt_r != n_r) rd_cnt_r <= rd_cnt_r + CW'(1);
          rd_valid_r <= 1'b1;
          if (rd_valid_r) begin
            acc_r <= (acc_r == '1 || add_sum[AccBits]) ? '1 : add_sum[AccBits-1:0];
          end
          if (state_nxt != S_ACC) begin
            norm_r    <= DW'(add_sum[AccBits] || acc_r == '1 ? '1 : add_sum[AccBits-1:0]);
            sq_op_r   <= SQW'(add_sum[AccBits] || acc_r == '1 ? '1 : add_sum[AccBits-1:0])
                         << (2 * L2Guard);
            sq_rem_r  <= '0;
            sq_root_r <= '0;
            step_r    <= '0;
            rd_cnt_r  <= '0;
          end
        end
        S_SQRT: begin
          step_r  <= step_r + 7'd1;
          sq_op_r <= sq_op_r << 2;
          if (!sq_trial[SQW+1]) begin
            sq_rem_r  <= sq_trial;
            sq_root_r <= {sq_root_r[RW-2:0], 1'b1};
          end else begin
            sq_rem_r  <= sq_rem_sh;
            sq_root_r <= {sq_root_r[RW-2:0], 1'b0};
          end
          if (step_r == 7'(SQI - 1)) begin
            norm_r <= DW'({sq_root_r[RW-2:0], !sq_trial[SQW+1]});
            step_r <= '0;
          end
        end
        S_RD: begin
          // memory read lands next cycle; divide starts there
          rd_cnt_r <= rd_cnt_r + CW'(1);
          step_r   <= '0;
        end
        S_DIV: begin
          if (step_r == 7'd0) begin
            // load numerator: magnitude scaled to Q1.F, plus the guard bits in L2
            num_r <= l1_r ? NW'(rd_mag) << F : NW'(rd_mag) << (F + L2Guard);
            rem_r <= '0;
            quo_r <= '0;
            neg_r <= rd_neg;
          end else begin
            num_r <= num_r << 1;
            if (!div_tr[DW+1]) begin
              rem_r <= div_tr[DW:0];
              quo_r <= {quo_r[QW-2:0], 1'b1};
            end else begin
              rem_r <= div_sh[DW:0];
              quo_r <= {quo_r[QW-2:0], 1'b0};
            end
          end
          step_r <= step_r + 7'd1;
        end
        S_OUT: begin
          out_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT) begin
      out_out_value <= out_v;
      out_last      <= (rd_cnt_r == n_r);
    end
  end

  property p_out_busy;
    @(posedge clk) disable iff (!rst_n) out_valid |-> $past(busy);
  endproperty
  a_out_busy: assert property (p_out_busy) else $error("result outside vector");
  property p_last_idle;
    @(posedge clk) disable iff (!rst_n) (out_valid && out_last) |-> !busy;
  endproperty
  a_last_idle: assert property (p_last_idle) else $error("busy after last");
endmodule
`default_nettype wire

// ===== test/lpn_checker.sv =====
// Checker: watches the normalizer's channels, predicts each vector's results and compares them.
`timescale 1ns / 1ps
module lpn_checker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic               busy,
  input  wire logic signed [15:0] in_sample,
  input  wire logic               out_valid,
  input  wire logic signed [15:0] out_out_value,
  input  wire logic               out_last,
  input  wire logic               cfg_we,
  input  wire logic [lpn_pkg::IdxBits-1:0] cfg_index,
  input  wire logic [lpn_pkg::CfgBits-1:0] cfg_data,
  output int                      fail_count,
  output int                      pending
);
  import lpn_pkg::*;

  typedef struct packed {
    logic signed [15:0] value;
    logic               last;
  } norm_result_t;

  localparam longint unsigned AccLimit = (64'd1 << AccBits) - 1;

  norm_result_t       expected_results[$];
  logic        [15:0] vec_store [64];
  int unsigned        stored;
  logic        [1:0]  order_reg;
  logic        [6:0]  length_reg;

  function automatic longint unsigned int_sqrt(longint unsigned a);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > a) b >>= 2;
    while (b != 0) begin
      if (a >= r + b) begin
        a -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned mag_of(logic [15:0] raw);
    return raw[15] ? longint'(17'h10000 - {1'b0, raw}) : longint'(raw);
  endfunction

  // Store one sample; on the closing sample push the whole normalized vector.
  task automatic take_sample(logic [15:0] s);
    int unsigned     len, n;
    bit              l1;
    longint unsigned acc, norm, mg, q, term;
    norm_result_t    r;
    len = (length_reg == 0) ? 1 : (length_reg > 64 ? 64 : length_reg);
    l1 = (order_reg == OrderL1);
    if (stored < 64) vec_store[stored] = s;
    stored++;
    if (stored < len) return;
    n = (stored > 64) ? 64 : stored;
    acc = 0;
    for (int i = 0; i < n; i++) begin
      mg = mag_of(vec_store[i]);
      term = l1 ? mg : mg * mg;
      acc = (acc >= AccLimit || term >= AccLimit - acc) ? AccLimit : acc + term;
    end
    norm = l1 ? acc : int_sqrt(acc << (2 * L2Guard));
    for (int i = 0; i < n; i++) begin
      mg = mag_of(vec_store[i]);
      q = 0;
      if (norm != 0) q = ((mg << (l1 ? 15 : 15 + L2Guard)) + norm / 2) / norm;
      if (vec_store[i][15]) begin
        if (q > 32768) q = 32768;
        r.value = -q[15:0];
      end else begin
        if (q > 32767) q = 32767;
        r.value = q[15:0];
      end
      r.last = (i + 1 == n);
      expected_results.push_back(r);
    end
    stored = 0;
  endtask

  task automatic r_check(norm_result_t e);
    if (out_out_value !== e.value) begin
      $display("%0t: value mismatch expected %0d actual %0d", $time, e.value, out_out_value);
      fail_count++;
    end
    if (out_last !== e.last) begin
      $display("%0t: last mismatch expected %0b actual %0b", $time, e.last, out_last);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_results.delete();
      stored     = 0;
      order_reg  = 2'd2;
      length_reg = 7'd64;
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == RegNormOrder) order_reg = cfg_data[1:0];
        else if (cfg_index == RegVecLen) length_reg = cfg_data;
      end
      if (start && !busy) take_sample(in_sample);
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result value=%0d last=%0b",
                   $time, out_out_value, out_last);
          fail_count++;
        end else begin
          r_check(expected_results.pop_front());
        end
      end
    end
    pending <= expected_results.size();
  end
endmodule

// ===== test/tb.sv =====
// Testbench top: drives sample requests and register writes into the normalizer and gives the verdict.
`timescale 1ns / 1ps
module tb;
  import lpn_pkg::*;

  localparam int CycleLimit = 400000;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic signed [15:0] in_sample;
  logic               out_valid;
  logic signed [15:0] out_out_value;
  logic               out_last;
  logic               cfg_we;
  logic [IdxBits-1:0] cfg_index;
  logic [CfgBits-1:0] cfg_data;
  int                 fail_count;
  int                 pending;
  int                 cycles;
  int                 sent;

  lp_vector_normalizer dut (
    .clk, .rst_n, .start, .busy, .in_sample, .out_valid, .out_out_value,
    .out_last, .cfg_we, .cfg_index, .cfg_data
  );

  lpn_checker chk (
    .clk, .rst_n, .start, .busy, .in_sample, .out_valid, .out_out_value,
    .out_last, .cfg_we, .cfg_index, .cfg_data, .fail_count, .pending
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Watchdog: end the run if the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Present one request and hold it until busy is low at a rising edge.
  task automatic send_sample(logic [15:0] v);
    start     <= 1'b1;
    in_sample <= v;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    sent++;
  endtask

  // Drop start for a random gap: mostly short, now and then long.
  task automatic idle_gap();
    int g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) g = 0;
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Drain all results, let the block settle, then write a register.
  task automatic write_reg(logic [IdxBits-1:0] idx, logic [CfgBits-1:0] val);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 9)) inside
      0:       return 16'h0000;
      1:       return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      [2:3]:   return 16'($signed($urandom_range(0, 512)) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_vector(int n, bit gaps);
    repeat (n) begin
      send_sample(pick_sample());
      if (gaps) idle_gap();
    end
  endtask

  initial begin
    int len;
    sent      = 0;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_sample = '0;
    cfg_we    = 1'b0;
    cfg_index = RegNormOrder;
    cfg_data  = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: L2 over a single long vector of mixed extremes.
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    send_sample(16'h0001);
    send_sample(16'hFFFF);
    send_vector(60, 1'b1);

    // Single-sample vectors hit saturation at plus and minus one.
    write_reg(RegVecLen, 7'd1);
    write_reg(RegNormOrder, 7'(OrderL1));
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    send_sample(16'h0000);
    write_reg(RegNormOrder, 7'd3);
    send_sample(16'h8000);
    send_sample(16'h1234);

    // Zero-norm vector, and length zero acting as one.
    write_reg(RegVecLen, 7'd3);
    write_reg(RegNormOrder, 7'd0);
    repeat (3) send_sample(16'h0000);
    write_reg(RegVecLen, 7'd0);
    send_sample(16'hC000);

    // Change length and order in the middle of a vector; stored samples stay.
    write_reg(RegVecLen, 7'd8);
    send_sample(16'h4000);
    send_sample(16'hC000);
    send_sample(16'h2000);
    write_reg(RegVecLen, 7'd4);
    write_reg(RegNormOrder, 7'(OrderL1));
    send_sample(16'h8000);

    // Length above the maximum acts as the maximum.
    write_reg(RegVecLen, 7'd127);
    send_vector(64, 1'b0);

    // Random phases: mostly short vectors, a few long ones.
    while (sent < 360) begin
      write_reg(RegNormOrder, 7'($urandom_range(0, 3)));
      case ($urandom_range(0, 9)) inside
        0:       len = $urandom_range(0, 1) ? 64 : $urandom_range(0, 127);
        [1:2]:   len = $urandom_range(9, 40);
        default: len = $urandom_range(1, 8);
      endcase
      write_reg(RegVecLen, 7'(len));
      if (len == 0) len = 1;
      if (len > 64) len = 64;
      for (int k = $urandom_range(1, 4); k > 0; k--) begin
        if (sent < 360) send_vector(len, $urandom_range(0, 3) != 0);
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
